>>> rtl/cc_pkg.sv
// Shared constants, types and the microcode ROM of the Chebyshev coefficient generator.
// No dependencies; imported by the top level and by both bench files.
package cc_pkg;

  localparam int MaxOrder  = 30;
  localparam int CoefWidth = 48;
  localparam int RowDepth  = MaxOrder + 1;
  localparam int AddrWidth = $clog2(RowDepth);
  localparam int UpcWidth  = 4;
  localparam int NumBanks  = 3;

  typedef logic signed [CoefWidth-1:0] coef_t;
  typedef logic [AddrWidth-1:0]        addr_t;
  typedef logic [UpcWidth-1:0]         upc_t;
  typedef logic [1:0]                  bank_t;

  typedef enum logic [3:0] {
    OpNop   = 4'd0,
    OpCheck = 4'd1,
    OpInit0 = 4'd2,
    OpInit1 = 4'd3,
    OpRow   = 4'd4,
    OpDrain = 4'd5,
    OpOutRd = 4'd6,
    OpOutLd = 4'd7,
    OpOutNx = 4'd8,
    OpErr   = 4'd9
  } op_e;

  typedef enum logic [3:0] {
    CondNone     = 4'd0,
    CondAlways   = 4'd1,
    CondNoReq    = 4'd2,
    CondBadOrder = 4'd3,
    CondLowOrder = 4'd4,
    CondRowBusy  = 4'd5,
    CondMoreRows = 4'd6,
    CondOutBusy  = 4'd7,
    CondMoreOut  = 4'd8
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    upc_t  target;
  } uword_t;

  localparam upc_t UpcIdle    = 4'd0;
  localparam upc_t UpcCheck   = 4'd1;
  localparam upc_t UpcInit0   = 4'd2;
  localparam upc_t UpcInit1   = 4'd3;
  localparam upc_t UpcRow     = 4'd4;
  localparam upc_t UpcDrain   = 4'd5;
  localparam upc_t UpcOutRd   = 4'd6;
  localparam upc_t UpcOutLd   = 4'd7;
  localparam upc_t UpcOutNx   = 4'd8;
  localparam upc_t UpcDone    = 4'd9;
  localparam upc_t UpcErr     = 4'd10;
  localparam upc_t UpcErrDone = 4'd11;

  function automatic uword_t ucode_rom(upc_t upc);
    uword_t w;
    case (upc)
      UpcIdle:    w = '{OpNop,   CondNoReq,    UpcIdle};
      UpcCheck:   w = '{OpCheck, CondBadOrder, UpcErr};
      UpcInit0:   w = '{OpInit0, CondNone,     UpcIdle};
      UpcInit1:   w = '{OpInit1, CondLowOrder, UpcOutRd};
      UpcRow:     w = '{OpRow,   CondRowBusy,  UpcRow};
      UpcDrain:   w = '{OpDrain, CondMoreRows, UpcRow};
      UpcOutRd:   w = '{OpOutRd, CondNone,     UpcIdle};
      UpcOutLd:   w = '{OpOutLd, CondOutBusy,  UpcOutLd};
      UpcOutNx:   w = '{OpOutNx, CondMoreOut,  UpcOutRd};
      UpcDone:    w = '{OpNop,   CondAlways,   UpcIdle};
      UpcErr:     w = '{OpErr,   CondOutBusy,  UpcErr};
      UpcErrDone: w = '{OpNop,   CondAlways,   UpcIdle};
      default:    w = '{OpNop,   CondAlways,   UpcIdle};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/cc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 31
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> rtl/chebyshev_coefficient_generator.sv
// Top level of the Chebyshev coefficient generator: microcode sequencer and row datapath.
// Depends on cc_pkg and three cc_ram row banks.
//
// Usage: a request carries an order n on order_i, taken when in_valid_i is high and
// in_stall_o is low. The block then streams n+1 results on coefficient_o / power_o /
// last_o / order_error_o, highest power first, with last_o set on the constant term.
// An order above 30 yields one result with order_error_o set and a zero coefficient.
// Rows T(2)..T(n) are built in three rotating RAM banks, one entry per cycle through
// the registered bank read, each row followed by a drain step. Each coefficient then
// passes through the read, load and advance steps of the output path. One request is
// worked at a time: in_stall_o stays high from acceptance until the sequencer is back
// in idle after the last result has been loaded into the output register. Results sit
// in that register until taken; while it is full and out_stall_i is high the
// sequencer holds at its load step and the payload is unchanged. Reset clears the
// sequencer and the output valid; the row banks need no clearing since only entries
// written by the current request are ever read.
module chebyshev_coefficient_generator (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [5:0]      order_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output cc_pkg::coef_t   coefficient_o,
  output logic [4:0]      power_o,
  output logic            last_o,
  output logic            order_error_o
);
  import cc_pkg::*;

  upc_t   upc_q, upc_d;
  uword_t uw;
  logic   accept, out_free, cond_hit, load_coef, load_err;

  logic [5:0] order_q, order_d;
  addr_t      i_q, i_d, p_q, p_d, k_q, k_d, pp_q, pp_d;
  logic       wr_pipe_q, wr_pipe_d;
  bank_t      prev_q, prev_d, prev2_q, prev2_d, next_q, next_d;

  logic         out_valid_q, out_valid_d;
  coef_t        coef_q, coef_d;
  logic [4:0]   power_q, power_d;
  logic         last_q, last_d, err_q, err_d;

  logic  bank_we    [NumBanks];
  addr_t bank_waddr [NumBanks];
  addr_t bank_raddr [NumBanks];
  coef_t bank_wdata [NumBanks];
  coef_t bank_rdata [NumBanks];

  coef_t prev_term, prev2_term, next_val;

  assign uw         = ucode_rom(upc_q);
  assign in_stall_o = (upc_q != UpcIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    case (uw.cond)
      CondNone:     cond_hit = 1'b0;
      CondAlways:   cond_hit = 1'b1;
      CondNoReq:    cond_hit = !accept;
      CondBadOrder: cond_hit = (order_q > 6'(MaxOrder));
      CondLowOrder: cond_hit = (order_q < 6'd2);
      CondRowBusy:  cond_hit = (p_q != i_q);
      CondMoreRows: cond_hit = ({1'b0, i_q} < order_q);
      CondOutBusy:  cond_hit = !out_free;
      CondMoreOut:  cond_hit = (k_q != '0);
      default:      cond_hit = 1'b0;
    endcase
    upc_d = cond_hit ? uw.target : upc_t'(upc_q + 1'b1);
  end

  for (genvar b = 0; b < NumBanks; b++) begin : g_bank
    cc_ram #(
      .WIDTH(CoefWidth),
      .DEPTH(RowDepth)
    ) u_bank (
      .clk_i  (clk_i),
      .we_i   (bank_we[b]),
      .waddr_i(bank_waddr[b]),
      .wdata_i(bank_wdata[b]),
      .raddr_i(bank_raddr[b]),
      .rdata_o(bank_rdata[b])
    );
  end

  always_comb begin
    prev_term  = (pp_q == '0) ? '0 : coef_t'(bank_rdata[prev_q] <<< 1);
    prev2_term = (({1'b0, pp_q} + 6'd2) > {1'b0, i_q}) ? '0 : bank_rdata[prev2_q];
    next_val   = coef_t'(prev_term - prev2_term);
  end

  always_comb begin
    for (int b = 0; b < NumBanks; b++) begin
      bank_we[b]    = wr_pipe_q && (next_q == bank_t'(b));
      bank_waddr[b] = pp_q;
      bank_wdata[b] = next_val;
      bank_raddr[b] = k_q;
    end
    case (uw.op)
      OpInit0: begin
        bank_we[0]    = 1'b1;
        bank_waddr[0] = '0;
        bank_wdata[0] = coef_t'(1);
        bank_we[1]    = 1'b1;
        bank_waddr[1] = '0;
        bank_wdata[1] = '0;
      end
      OpInit1: begin
        bank_we[1]    = 1'b1;
        bank_waddr[1] = addr_t'(1);
        bank_wdata[1] = coef_t'(1);
      end
      OpRow: begin
        bank_raddr[prev_q]  = (p_q == '0) ? '0 : addr_t'(p_q - 1'b1);
        bank_raddr[prev2_q] = p_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    order_d   = order_q;
    i_d       = i_q;
    p_d       = p_q;
    k_d       = k_q;
    pp_d      = pp_q;
    wr_pipe_d = 1'b0;
    prev_d    = prev_q;
    prev2_d   = prev2_q;
    next_d    = next_q;
    load_coef = 1'b0;
    load_err  = 1'b0;
    if (accept) begin
      order_d = order_i;
    end
    case (uw.op)
      OpInit1: begin
        i_d     = addr_t'(2);
        p_d     = '0;
        k_d     = order_q[AddrWidth-1:0];
        prev_d  = (order_q == '0) ? bank_t'(0) : bank_t'(1);
        prev2_d = bank_t'(0);
        next_d  = bank_t'(2);
      end
      OpRow: begin
        pp_d      = p_q;
        wr_pipe_d = 1'b1;
        if (p_q != i_q) begin
          p_d = addr_t'(p_q + 1'b1);
        end
      end
      OpDrain: begin
        prev2_d = prev_q;
        prev_d  = next_q;
        next_d  = prev2_q;
        i_d     = addr_t'(i_q + 1'b1);
        p_d     = '0;
      end
      OpOutLd: begin
        load_coef = out_free;
      end
      OpOutNx: begin
        if (k_q != '0) begin
          k_d = addr_t'(k_q - 1'b1);
        end
      end
      OpErr: begin
        load_err = out_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    coef_d      = coef_q;
    power_d     = power_q;
    last_d      = last_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (load_coef) begin
      coef_d      = bank_rdata[prev_q];
      power_d     = 5'(k_q);
      last_d      = (k_q == '0);
      err_d       = 1'b0;
      out_valid_d = 1'b1;
    end else if (load_err) begin
      coef_d      = '0;
      power_d     = '0;
      last_d      = 1'b1;
      err_d       = 1'b1;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= UpcIdle;
      wr_pipe_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      wr_pipe_q   <= wr_pipe_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    order_q <= order_d;
    i_q     <= i_d;
    p_q     <= p_d;
    k_q     <= k_d;
    pp_q    <= pp_d;
    prev_q  <= prev_d;
    prev2_q <= prev2_d;
    next_q  <= next_d;
    coef_q  <= coef_d;
    power_q <= power_d;
    last_q  <= last_d;
    err_q   <= err_d;
  end

  assign out_valid_o   = out_valid_q;
  assign coefficient_o = coef_q;
  assign power_o       = power_q;
  assign last_o        = last_q;
  assign order_error_o = err_q;

endmodule

>>> bench/chebyshev_coefficient_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the Chebyshev coefficient generator. It watches the request and result
// channels, predicts each coefficient stream and compares every result field by field.
// Depends on cc_pkg for the coefficient type, the row depth and the maximum order.
module chebyshev_coefficient_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  logic [5:0]    order_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  cc_pkg::coef_t coefficient_i,
  input  logic [4:0]    power_i,
  input  logic          last_i,
  input  logic          order_error_i,
  output int            fail_count_o,
  output int            pending_o
);
  import cc_pkg::*;

  typedef struct {
    coef_t      coefficient;
    logic [4:0] power;
    logic       last;
    logic       order_error;
  } term_t;

  term_t expected_terms[$];

  task automatic expand_polynomial(input logic [5:0] order);
    coef_t two_back [RowDepth];
    coef_t one_back [RowDepth];
    coef_t step_row [RowDepth];
    term_t t;
    if (order > MaxOrder) begin
      t.coefficient = '0;
      t.power       = '0;
      t.last        = 1'b1;
      t.order_error = 1'b1;
      expected_terms.push_back(t);
    end else begin
      for (int p = 0; p < RowDepth; p++) begin
        two_back[p] = '0;
        one_back[p] = '0;
        step_row[p] = '0;
      end
      two_back[0] = coef_t'(1);
      one_back[1] = coef_t'(1);
      if (order == 0) one_back = two_back;
      // T(i) = 2x T(i-1) - T(i-2), wrapping at the coefficient width
      for (int i = 2; i <= order; i++) begin
        step_row[0] = -two_back[0];
        for (int p = 1; p < RowDepth; p++) begin
          step_row[p] = (one_back[p-1] <<< 1) - two_back[p];
        end
        two_back = one_back;
        one_back = step_row;
      end
      for (int p = order; p >= 0; p--) begin
        t.coefficient = one_back[p];
        t.power       = 5'(p);
        t.last        = (p == 0);
        t.order_error = 1'b0;
        expected_terms.push_back(t);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    term_t want;
    int    errs;
    errs = 0;
    if (!rst_ni) begin
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_terms.size() == 0) begin
          $error("result with nothing expected: power %0d coefficient %0d",
                 power_i, coefficient_i);
          errs++;
        end else begin
          want = expected_terms.pop_front();
          if (coefficient_i !== want.coefficient) begin
            $error("coefficient: expected %0d, actual %0d", want.coefficient, coefficient_i);
            errs++;
          end
          if (power_i !== want.power) begin
            $error("power: expected %0d, actual %0d", want.power, power_i);
            errs++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, last_i);
            errs++;
          end
          if (order_error_i !== want.order_error) begin
            $error("order_error: expected %0b, actual %0b", want.order_error, order_error_i);
            errs++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) expand_polynomial(order_i);
      fail_count_o <= fail_count_o + errs;
      pending_o    <= expected_terms.size();
    end
  end

endmodule

>>> bench/chebyshev_coefficient_generator_tb.sv
`timescale 1ns / 1ps
// Top of the Chebyshev coefficient generator bench: clock, reset, order requests and
// random stalls, with the scoreboard in chebyshev_coefficient_checker beside the block.
// Depends on cc_pkg, chebyshev_coefficient_generator and chebyshev_coefficient_checker.
module chebyshev_coefficient_generator_tb;
  import cc_pkg::*;

  localparam int NumRandom   = 395;
  localparam int IdleLimit   = 20000;
  localparam int DrainCycles = 64;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [5:0] order_i     = '0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  coef_t      coefficient_o;
  logic [4:0] power_o;
  logic       last_o;
  logic       order_error_o;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  bit steady      = 1'b0;

  logic [5:0] directed_orders [17] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 15, 16, 29, 30, 31, 32, 42, 63};

  always #5 clk_i = ~clk_i;

  chebyshev_coefficient_generator DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .order_i,
    .out_valid_o,
    .out_stall_i,
    .coefficient_o,
    .power_o,
    .last_o,
    .order_error_o
  );

  chebyshev_coefficient_checker scoreboard (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i    (in_stall_o),
    .order_i,
    .out_valid_i   (out_valid_o),
    .out_stall_i,
    .coefficient_i (coefficient_o),
    .power_i       (power_o),
    .last_i        (last_o),
    .order_error_i (order_error_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && !steady && ($urandom_range(99) < 21);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAIL chebyshev_coefficient_generator");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [5:0] pick_order();
    if ($urandom_range(99) < 20) return 6'($urandom_range(63, MaxOrder + 1));
    return 6'($urandom_range(MaxOrder, 0));
  endfunction

  task automatic request_order(input logic [5:0] ord);
    while (!steady && $urandom_range(99) < 21) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    order_i    <= ord;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_orders[k]) request_order(directed_orders[k]);
    hold_until_drained();
    for (int k = 0; k < NumRandom; k++) begin
      steady <= (k >= 150 && k < 250);
      if (k == 300) hold_until_drained();
      request_order(pick_order());
    end
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS chebyshev_coefficient_generator");
    end else begin
      $display("FAIL chebyshev_coefficient_generator");
    end
    $finish;
  end

endmodule

>>> chebyshev_coefficient_generator.f
rtl/cc_pkg.sv
rtl/cc_ram.sv
rtl/chebyshev_coefficient_generator.sv
bench/chebyshev_coefficient_checker.sv
bench/chebyshev_coefficient_generator_tb.sv
